>>> rtl/core/base64_stream_decoder_macros.svh
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// condition holds in the same cycle
`define B64D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d assertion failed");

// condition holds in the following cycle
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d assertion failed");

`endif

>>> rtl/core/b64d_pkg.sv
// shared types, constants and character mapping for the base64 decoder
`default_nettype none
package b64d_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_PAD     = 8'h3d;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [5:0] LOWER_BASE   = 6'd26;
    localparam logic [5:0] DIGIT_BASE   = 6'd52;

    // one group waiting to be unpacked into bytes
    typedef struct packed {
        logic [23:0] block;
        logic [1:0]  nbytes;
        logic        msg_last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = c - CH_UPPER_A;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = c - CH_LOWER_A + {2'b00, LOWER_BASE};
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d = c - CH_DIGIT_0 + {2'b00, DIGIT_BASE};
        end else if (c == CH_PLUS) begin
            d = {2'b00, SEXTET_PLUS};
        end else if (c == CH_SLASH) begin
            d = {2'b00, SEXTET_SLASH};
        end else begin
            d = 8'd0;
        end
        return d[5:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/b64d_front.sv
// character intake: maps characters, gathers groups and issues byte jobs
`default_nettype none
module b64d_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_msg_end,
    output      logic              o_push,
    output      b64d_pkg::t_job    o_job
);

    logic [17:0] r_accum, n_accum;
    logic [1:0]  r_gcnt, n_gcnt;
    logic        r_prev_pad, n_prev_pad;

    logic [23:0] acc;
    logic [23:0] block;
    logic        is_pad;
    logic [1:0]  pads;
    logic [1:0]  nbytes;

    always_comb begin
        is_pad = (i_char == b64d_pkg::CH_PAD);
        acc    = {r_accum, b64d_pkg::sextet_of(i_char)};
        unique case (r_gcnt)
            2'd0:    block = {acc[5:0], 18'd0};
            2'd1:    block = {acc[11:0], 12'd0};
            2'd2:    block = {acc[17:0], 6'd0};
            default: block = acc;
        endcase
        pads = is_pad ? (r_prev_pad ? 2'd2 : 2'd1) : 2'd0;
        // a group of n characters gives n-1 bytes, less padding
        if (i_msg_end) begin
            nbytes = (r_gcnt > pads) ? (r_gcnt - pads) : 2'd0;
        end else begin
            nbytes = (r_gcnt == 2'd3) ? 2'd3 : 2'd0;
        end
        o_push         = i_accept && (nbytes != 2'd0);
        o_job.block    = block;
        o_job.nbytes   = nbytes;
        o_job.msg_last = i_msg_end;

        n_accum    = r_accum;
        n_gcnt     = r_gcnt;
        n_prev_pad = r_prev_pad;
        if (i_accept) begin
            if (i_msg_end) begin
                n_accum    = 18'd0;
                n_gcnt     = 2'd0;
                n_prev_pad = 1'b0;
            end else begin
                n_accum    = (r_gcnt == 2'd3) ? 18'd0 : acc[17:0];
                n_gcnt     = r_gcnt + 2'd1;
                n_prev_pad = is_pad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum    <= 18'd0;
            r_gcnt     <= 2'd0;
            r_prev_pad <= 1'b0;
        end else begin
            r_accum    <= n_accum;
            r_gcnt     <= n_gcnt;
            r_prev_pad <= n_prev_pad;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/b64d_queue.sv
// short job queue between intake and byte output
`default_nettype none
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire b64d_pkg::t_job        i_job,
    input  wire logic                  i_pop,
    output      b64d_pkg::t_job        o_job,
    output      b64d_pkg::t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_status.full  = (r_count == CNT_W'(DEPTH));
        o_status.empty = (r_count == '0);
        do_push = i_push && !o_status.full;
        do_pop  = i_pop && !o_status.empty;
        o_job   = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/b64d_back.sv
// byte output: unpacks queued jobs one byte per transfer
`default_nettype none
module b64d_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire b64d_pkg::t_job          i_job,
    input  wire b64d_pkg::t_queue_status i_status,
    output      logic                    o_pop,
    output      logic                    o_valid,
    input  wire logic                    i_ready,
    output      logic [7:0]              o_byte,
    output      logic                    o_run_end,
    output      logic                    o_stream_end
);

    logic       r_valid, n_valid;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_byte;
    logic       r_run_end;
    logic       r_stream_end;

    logic       load;
    logic       take;
    logic       fin;
    logic [7:0] sel_byte;

    always_comb begin
        load = !r_valid || i_ready;
        take = load && !i_status.empty;
        fin  = (r_idx == (i_job.nbytes - 2'd1));
        unique case (r_idx)
            2'd0:    sel_byte = i_job.block[23:16];
            2'd1:    sel_byte = i_job.block[15:8];
            default: sel_byte = i_job.block[7:0];
        endcase
        o_pop   = take && fin;
        n_valid = load ? !i_status.empty : r_valid;
        n_idx   = r_idx;
        if (take) begin
            n_idx = fin ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte       <= sel_byte;
            r_run_end    <= fin;
            r_stream_end <= fin && i_job.msg_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_run_end    = r_run_end;
    assign o_stream_end = r_stream_end;

endmodule
`default_nettype wire

>>> rtl/core/base64_stream_decoder.sv
// base64 stream decoder top level
//
// Takes one base64 character per transfer and gives decoded bytes, one per
// transfer. A character is taken every cycle while the job queue has room;
// each completed group of four becomes a job in a queue of QUEUE_DEPTH
// entries, and the output side unpacks one byte per cycle from the head job
// while the receiver is ready, so steady input at one character per cycle
// never stalls. The fourth character of a group is queued as a job; its first
// byte is then registered onto the output. Characters outside the alphabet,
// and '=', decode as zero bits; trailing '=' shortens only the final group.
// A message whose final group gives no bytes produces no byte with tlast set.
`default_nettype none
`include "base64_stream_decoder_macros.svh"
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output      logic       o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] char_code
    input  wire logic       i_s_tlast,   // message_end
    output      logic       o_m_tvalid,
    input  wire logic       i_m_tready,
    output      logic [7:0] o_m_tdata,   // [7:0] data_byte
    output      logic       o_m_tuser,   // [0] run_end
    output      logic       o_m_tlast    // stream_end
);

    b64d_pkg::t_job          push_job;
    b64d_pkg::t_job          head_job;
    b64d_pkg::t_queue_status q_status;
    logic                    push;
    logic                    pop;
    logic                    accept;

    assign o_s_tready = !q_status.full;
    assign accept     = i_s_tvalid && o_s_tready;

    b64d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_char    (i_s_tdata),
        .i_msg_end (i_s_tlast),
        .o_push    (push),
        .o_job     (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    b64d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_status     (q_status),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_run_end    (o_m_tuser),
        .o_stream_end (o_m_tlast)
    );

    `B64D_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, push, !q_status.full)
    `B64D_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, pop, !q_status.empty)
    `B64D_ASSERT_NOW(a_stream_end_run_end, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser)
    `B64D_ASSERT_NEXT(a_pop_gives_byte, i_clk, i_rst_n, pop, o_m_tvalid && o_m_tuser)

endmodule
`default_nettype wire

>>> test/base64_stream_decoder_test.sv
// self-checking testbench for the base64 stream decoder
module base64_stream_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int MAX_SEND_GAP   = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } t_decoded_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;
    logic       i_s_tlast;
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;
    logic       o_m_tuser;
    logic       o_m_tlast;

    t_decoded_byte pending_bytes[$];

    // decoder state as predicted
    logic [17:0] group_bits;
    logic [1:0]  group_chars;
    logic        last_was_pad;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_left;
    int mismatches;
    int chars_sent;
    int messages_sent;
    int bytes_checked;

    base64_stream_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] char_code
        .i_s_tlast  (i_s_tlast),   // message_end
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [7:0] data_byte
        .o_m_tuser  (o_m_tuser),   // [0] run_end
        .o_m_tlast  (o_m_tlast)    // stream_end
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [5:0] char_value(input logic [7:0] c);
        if (c >= b64d_pkg::CH_UPPER_A && c <= b64d_pkg::CH_UPPER_Z) begin
            return 6'(c - b64d_pkg::CH_UPPER_A);
        end else if (c >= b64d_pkg::CH_LOWER_A && c <= b64d_pkg::CH_LOWER_Z) begin
            return 6'(c - b64d_pkg::CH_LOWER_A) + b64d_pkg::LOWER_BASE;
        end else if (c >= b64d_pkg::CH_DIGIT_0 && c <= b64d_pkg::CH_DIGIT_9) begin
            return 6'(c - b64d_pkg::CH_DIGIT_0) + b64d_pkg::DIGIT_BASE;
        end else if (c == b64d_pkg::CH_PLUS) begin
            return b64d_pkg::SEXTET_PLUS;
        end else if (c == b64d_pkg::CH_SLASH) begin
            return b64d_pkg::SEXTET_SLASH;
        end
        return 6'd0;
    endfunction

    function automatic logic [7:0] symbol_char(input int idx);
        if (idx < b64d_pkg::LOWER_BASE) begin
            return b64d_pkg::CH_UPPER_A + 8'(idx);
        end else if (idx < b64d_pkg::DIGIT_BASE) begin
            return b64d_pkg::CH_LOWER_A + 8'(idx - b64d_pkg::LOWER_BASE);
        end else if (idx < b64d_pkg::SEXTET_PLUS) begin
            return b64d_pkg::CH_DIGIT_0 + 8'(idx - b64d_pkg::DIGIT_BASE);
        end else if (idx == b64d_pkg::SEXTET_PLUS) begin
            return b64d_pkg::CH_PLUS;
        end
        return b64d_pkg::CH_SLASH;
    endfunction

    task automatic predict_decoded_bytes(input logic [7:0] c, input logic msg_last);
        int          n;
        int          pads;
        int          nbytes;
        logic [23:0] acc;
        logic [23:0] blk;
        logic        fin;
        n = int'(group_chars) + 1;
        acc = {group_bits, char_value(c)};
        blk = acc << (6 * (4 - n));
        if (!msg_last) begin
            if (n == 4) begin
                pending_bytes.push_back('{blk[23:16], 1'b0, 1'b0});
                pending_bytes.push_back('{blk[15:8], 1'b0, 1'b0});
                pending_bytes.push_back('{blk[7:0], 1'b1, 1'b0});
                group_bits = '0;
                group_chars = '0;
            end else begin
                group_bits = acc[17:0];
                group_chars = 2'(n);
            end
            last_was_pad = (c == b64d_pkg::CH_PAD);
        end else begin
            pads = (c == b64d_pkg::CH_PAD) ? (last_was_pad ? 2 : 1) : 0;
            nbytes = (n * 3) / 4;
            nbytes = (nbytes > pads) ? nbytes - pads : 0;
            for (int i = 0; i < nbytes; i++) begin
                fin = (i + 1 == nbytes);
                pending_bytes.push_back('{blk[23 - 8 * i -: 8], fin, fin});
            end
            group_bits = '0;
            group_chars = '0;
            last_was_pad = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_char(input logic [7:0] c, input logic msg_last);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        @(negedge i_clk);
        while (gap > 0) begin
            i_s_tvalid <= 1'b0;
            gap--;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= c;
        i_s_tlast <= msg_last;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        predict_decoded_bytes(c, msg_last);
        chars_sent++;
        if (msg_last) begin
            messages_sent++;
        end
    endtask

    task automatic send_message_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // mostly well-formed text, some noise characters and stray padding
    task automatic send_random_message();
        int         len;
        int         npad;
        logic [7:0] c;
        len = $urandom_range(1, 14);
        npad = ($urandom_range(99) < 35) ? $urandom_range(1, 2) : 0;
        if (npad > len) begin
            npad = len;
        end
        for (int i = 0; i < len; i++) begin
            if (i >= len - npad) begin
                c = b64d_pkg::CH_PAD;
            end else if ($urandom_range(99) < 12) begin
                c = 8'($urandom_range(255));
            end else if ($urandom_range(99) < 4) begin
                c = b64d_pkg::CH_PAD;
            end else begin
                c = symbol_char($urandom_range(63));
            end
            send_char(c, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // single character gives nothing
        send_message_text("A");
        // out-of-alphabet codes and two pads in a full group
        send_char(8'h00, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(b64d_pkg::CH_PAD, 1'b0);
        send_char(b64d_pkg::CH_PAD, 1'b1);
        send_message_text("Zz9+/a0=");
        // pad pair as the whole final group, floored to nothing
        send_message_text("QUJD==");
        // pad mid-message, one-character final group
        send_message_text("S=x/9");
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_chars);
        int start;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            send_random_message();
        end
        wait_drained();
    endtask

    task automatic test_receiver_hold_off();
        int start;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_left = HOLD_OFF_CYCLES;
        start = chars_sent;
        while (chars_sent - start < 30) begin
            send_random_message();
        end
        wait_drained();
    endtask

    // receiver side: random stalls, or a long hold-off when requested
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_decoded_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("unexpected byte", o_m_tdata, 0);
            end else begin
                want = pending_bytes.pop_front();
                if (o_m_tdata !== want.data) begin
                    report_mismatch("data_byte", o_m_tdata, want.data);
                end
                if (o_m_tuser !== want.run_end) begin
                    report_mismatch("run_end", o_m_tuser, want.run_end);
                end
                if (o_m_tlast !== want.stream_end) begin
                    report_mismatch("stream_end", o_m_tlast, want.stream_end);
                end
                bytes_checked++;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL base64_stream_decoder");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_left = 0;
        mismatches = 0;
        chars_sent = 0;
        messages_sent = 0;
        bytes_checked = 0;
        group_bits = '0;
        group_chars = '0;
        last_was_pad = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(0, 0, 65);
        test_random_traffic(48, 0, 65);
        test_random_traffic(0, 48, 65);
        test_random_traffic(8, 8, 65);
        test_receiver_hold_off();

        if (pending_bytes.size() != 0) begin
            report_mismatch("bytes never received", 0, pending_bytes.size());
        end
        $display("sent %0d characters in %0d messages, checked %0d decoded bytes",
                 chars_sent, messages_sent, bytes_checked);
        $display("phases: directed cases, free flow, sender gaps, receiver stalls, both, hold-off");
        if (mismatches == 0) begin
            $display("PASS base64_stream_decoder");
        end else begin
            $display("FAIL base64_stream_decoder");
        end
        $finish;
    end

endmodule
